/* design/assert_macros.svh */
// Assertion helpers for this block. Clock aclk, synchronous reset aresetn
// (active low) must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define PBE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define PBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/pbe_pkg.sv */
`timescale 1ns / 1ps
package pbe_pkg;

    localparam int DEF_MAX_POINTS   = 256;
    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_MAX_ORDER    = 7;
    localparam int DEF_FRAC_BITS    = 16;

    localparam logic [31:0] BIAS          = 32'h8000_0000;
    localparam logic [2:0]  DEFAULT_ORDER = 3'd3;

    typedef enum logic [1:0] {
        FUNC_LOAD_POINT    = 2'd0,
        FUNC_LOAD_DURATION = 2'd1,
        FUNC_EVALUATE      = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_CURVE_ORDER   = 2'd0,
        CFG_POINT_COUNT   = 2'd1,
        CFG_SEGMENT_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG_RD,
        ST_SEG_CMP,
        ST_DIV,
        ST_PT_RD,
        ST_PT_CAP,
        ST_MUL,
        ST_ADD,
        ST_DROP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_point;
        logic load_duration;
        logic start_eval;
        logic seg_next;
        logic seg_take;
        logic div_step;
        logic pt_capture;
        logic lerp_mul;
        logic lerp_add;
        logic drop;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic seg_hit;
        logic u_ready;
        logic pt_last;
        logic pass_end;
        logic cnt_two;
        logic out_busy;
    } dp_sts_t;

endpackage

/* design/pbe_ctrl.sv */
`timescale 1ns / 1ps
module pbe_ctrl
    import pbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        FUNC_LOAD_POINT:    cmd.load_point    = 1'b1;
                        FUNC_LOAD_DURATION: cmd.load_duration = 1'b1;
                        FUNC_EVALUATE: begin
                            cmd.start_eval = 1'b1;
                            state_next     = sts.empty ? ST_OUT : ST_SEG_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEG_RD: state_next = ST_SEG_CMP;
            ST_SEG_CMP: begin
                if (sts.seg_hit) begin
                    cmd.seg_take = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.seg_next = 1'b1;
                    state_next   = ST_SEG_RD;
                end
            end
            ST_DIV: begin
                if (sts.u_ready) begin
                    state_next = ST_PT_RD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_PT_RD: state_next = ST_PT_CAP;
            ST_PT_CAP: begin
                cmd.pt_capture = 1'b1;
                state_next     = sts.pt_last ? ST_MUL : ST_PT_RD;
            end
            ST_MUL: begin
                cmd.lerp_mul = 1'b1;
                state_next   = ST_ADD;
            end
            ST_ADD: begin
                cmd.lerp_add = 1'b1;
                state_next   = sts.pass_end ? ST_DROP : ST_MUL;
            end
            ST_DROP: begin
                cmd.drop   = 1'b1;
                state_next = sts.cnt_two ? ST_OUT : ST_MUL;
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* design/pbe_datapath.sv */
`timescale 1ns / 1ps
module pbe_datapath
    import pbe_pkg::*;
#(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int MAX_ORDER    = DEF_MAX_ORDER,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data,
    input  logic [167:0] s_tdata,
    input  dp_cmd_t      cmd,
    output dp_sts_t      sts,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,
    output logic [0:0]   m_tuser
);

    localparam int N    = MAX_ORDER + 1;
    localparam int PAW  = $clog2(MAX_POINTS);
    localparam int SAW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NPW  = $clog2(MAX_POINTS + 1);
    localparam int SCW  = $clog2(MAX_SEGMENTS + 1);
    localparam int OW   = $clog2(MAX_ORDER + 1);
    localparam int CNW  = $clog2(N + 1);
    localparam int PCW  = (NPW > 9) ? NPW : 9;
    localparam int SGW  = (SCW > 7) ? SCW : 7;
    localparam int OCW  = (OW > 3) ? OW : 3;
    localparam int EPW  = (PAW + 1 > 9) ? PAW + 1 : 9;
    localparam int ESW  = (SAW + 1 > 9) ? SAW + 1 : 9;
    localparam int PIW0 = $clog2(MAX_SEGMENTS * MAX_ORDER + MAX_ORDER + 1) + 1;
    localparam int PIW  = (PIW0 > NPW + 1) ? PIW0 : NPW + 1;
    localparam int DCW  = $clog2(FRAC_BITS);
    localparam int UW   = FRAC_BITS + 1;
    localparam int PW   = 33 + FRAC_BITS;
    localparam int SW   = PW + 1;
    localparam logic [UW-1:0] U_ONE = UW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] HALF  = SW'(1) << (FRAC_BITS - 1);

    // input fields
    logic [7:0]  entry_index;
    logic [31:0] pin [3];
    logic [31:0] segment_duration, query_time;
    assign entry_index      = s_tdata[7:0];
    assign pin[0]           = s_tdata[39:8];
    assign pin[1]           = s_tdata[71:40];
    assign pin[2]           = s_tdata[103:72];
    assign segment_duration = s_tdata[135:104];
    assign query_time       = s_tdata[167:136];

    // configuration
    logic [2:0] curve_order_reg;
    logic [8:0] point_count_reg;
    logic [6:0] segment_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_order_reg   <= '0;
            point_count_reg   <= '0;
            segment_count_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CURVE_ORDER:   curve_order_reg   <= cfg_data[2:0];
                CFG_POINT_COUNT:   point_count_reg   <= cfg_data;
                CFG_SEGMENT_COUNT: segment_count_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // saturated counts and order
    logic [PCW-1:0] pc_ext, npts_sat;
    logic [SGW-1:0] sc_ext, nseg_sat;
    logic [OCW-1:0] ord_ext, ord_sat;
    always_comb begin
        pc_ext   = PCW'(point_count_reg);
        npts_sat = (pc_ext > PCW'(MAX_POINTS)) ? PCW'(MAX_POINTS) : pc_ext;
        sc_ext   = SGW'(segment_count_reg);
        nseg_sat = (sc_ext > SGW'(MAX_SEGMENTS)) ? SGW'(MAX_SEGMENTS) : sc_ext;
        ord_ext  = (curve_order_reg == 3'd0) ? OCW'(DEFAULT_ORDER) : OCW'(curve_order_reg);
        ord_sat  = (ord_ext > OCW'(MAX_ORDER)) ? OCW'(MAX_ORDER) : ord_ext;
    end

    // stores
    logic [31:0] mem_x [MAX_POINTS];
    logic [31:0] mem_y [MAX_POINTS];
    logic [31:0] mem_z [MAX_POINTS];
    logic [31:0] mem_d [MAX_SEGMENTS];
    logic [31:0] rd_pt [3];
    logic [31:0] rd_dur;

    logic [EPW-1:0] ei_p;
    logic [ESW-1:0] ei_s;
    logic           pt_in_range, seg_in_range;
    assign ei_p         = EPW'(entry_index);
    assign ei_s         = ESW'(entry_index);
    assign pt_in_range  = ei_p < EPW'(MAX_POINTS);
    assign seg_in_range = ei_s < ESW'(MAX_SEGMENTS);

    logic [PAW-1:0] pt_addr;
    logic [SAW-1:0] i_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_point && pt_in_range) begin
            mem_x[ei_p[PAW-1:0]] <= pin[0];
            mem_y[ei_p[PAW-1:0]] <= pin[1];
            mem_z[ei_p[PAW-1:0]] <= pin[2];
        end
        rd_pt[0] <= mem_x[pt_addr];
        rd_pt[1] <= mem_y[pt_addr];
        rd_pt[2] <= mem_z[pt_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_duration && seg_in_range) begin
            mem_d[ei_s[SAW-1:0]] <= segment_duration;
        end
        rd_dur <= mem_d[i_reg];
    end

    // evaluation state
    logic           empty_reg;
    logic [NPW-1:0] npts_reg;
    logic [SCW-1:0] nseg_reg;
    logic [OW-1:0]  order_reg;
    logic [31:0]    t_reg;
    logic [31:0]    d_reg;
    logic [31:0]    r_reg;
    logic [UW-1:0]  u_reg;
    logic           u_ready_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [PIW-1:0] base_reg;
    logic [OW-1:0]  g_reg;
    logic [CNW-1:0] cnt_reg;
    logic [CNW-1:0] k_reg;
    logic [31:0]    p_reg  [3][N];
    logic [PW-1:0]  pa_reg [3];
    logic [PW-1:0]  pb_reg [3];

    // point address with clamp to last loaded point
    logic [PIW-1:0] pidx, plast;
    always_comb begin
        pidx    = base_reg + PIW'(g_reg);
        plast   = PIW'(npts_reg) - PIW'(1);
        pidx    = (pidx > plast) ? plast : pidx;
        pt_addr = pidx[PAW-1:0];
    end

    // divider step: remainder stays below d
    logic [32:0] r2;
    logic        q_bit;
    assign r2    = {r_reg, 1'b0};
    assign q_bit = r2 >= {1'b0, d_reg};

    // interpolation sums
    logic [UW-1:0] om;
    logic [SW-1:0] lsum [3];
    logic [31:0]   lnew [3];
    assign om = U_ONE - u_reg;
    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            lsum[ax] = SW'(pa_reg[ax]) + SW'(pb_reg[ax]) + HALF;
            lnew[ax] = lsum[ax][FRAC_BITS +: 32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_ready_reg <= 1'b0;
            i_reg       <= '0;
            g_reg       <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            dcnt_reg    <= '0;
        end else begin
            if (cmd.start_eval) begin
                i_reg <= '0;
            end
            if (cmd.seg_next) begin
                i_reg <= i_reg + SAW'(1);
            end
            if (cmd.seg_take) begin
                g_reg    <= '0;
                dcnt_reg <= '0;
                // t >= d already saturates u; zero duration gives u = 1
                u_ready_reg <= (rd_dur == 32'd0) || (t_reg >= rd_dur);
            end
            if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(FRAC_BITS - 1)) begin
                    u_ready_reg <= 1'b1;
                end
            end
            if (cmd.pt_capture) begin
                g_reg <= g_reg + OW'(1);
                if (g_reg == order_reg) begin
                    cnt_reg <= CNW'(order_reg) + CNW'(1);
                    k_reg   <= '0;
                end
            end
            if (cmd.lerp_add) begin
                k_reg <= k_reg + CNW'(1);
            end
            if (cmd.drop) begin
                cnt_reg <= cnt_reg - CNW'(1);
                k_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_eval) begin
            empty_reg <= (point_count_reg == 9'd0) || (segment_count_reg == 7'd0);
            npts_reg  <= npts_sat[NPW-1:0];
            nseg_reg  <= nseg_sat[SCW-1:0];
            order_reg <= ord_sat[OW-1:0];
            t_reg     <= query_time[31] ? 32'd0 : query_time;
        end
        if (cmd.seg_next) begin
            t_reg <= t_reg - rd_dur;
        end
        if (cmd.seg_take) begin
            d_reg    <= rd_dur;
            r_reg    <= t_reg;
            u_reg    <= ((rd_dur == 32'd0) || (t_reg >= rd_dur)) ? U_ONE : '0;
            base_reg <= PIW'(i_reg) * PIW'(order_reg);
        end
        if (cmd.div_step) begin
            r_reg <= q_bit ? 32'(r2 - {1'b0, d_reg}) : r2[31:0];
            u_reg <= {u_reg[UW-2:0], q_bit};
        end
        for (int ax = 0; ax < 3; ax++) begin
            if (cmd.pt_capture) begin
                p_reg[ax][g_reg] <= rd_pt[ax] ^ BIAS;
            end
            if (cmd.lerp_mul) begin
                pa_reg[ax] <= PW'(p_reg[ax][0]) * PW'(om);
                pb_reg[ax] <= PW'(p_reg[ax][1]) * PW'(u_reg);
            end
            if (cmd.lerp_add || cmd.drop) begin
                for (int j = 0; j < N; j++) begin
                    if (cmd.lerp_add && (CNW'(j) == cnt_reg - CNW'(1))) begin
                        p_reg[ax][j] <= lnew[ax];
                    end else if (j < N - 1) begin
                        p_reg[ax][j] <= p_reg[ax][(j < N - 1) ? j + 1 : j];
                    end
                end
            end
        end
    end

    // output register
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_valid_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_valid_res_reg <= !empty_reg;
            if (empty_reg) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {p_reg[2][0] ^ BIAS, p_reg[1][0] ^ BIAS, p_reg[0][0] ^ BIAS};
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_valid_res_reg;

    // status
    assign sts.empty    = (point_count_reg == 9'd0) || (segment_count_reg == 7'd0);
    assign sts.seg_hit  = (t_reg <= rd_dur) || (SCW'(i_reg) == nseg_reg - SCW'(1));
    assign sts.u_ready  = u_ready_reg;
    assign sts.pt_last  = g_reg == order_reg;
    assign sts.pass_end = k_reg == cnt_reg - CNW'(2);
    assign sts.cnt_two  = cnt_reg == CNW'(2);
    assign sts.out_busy = m_tvalid_reg && !m_tready;

endmodule

/* design/piecewise_bezier_evaluator.sv */
`timescale 1ns / 1ps
// Piecewise 3D Bezier evaluator. Load transfers (tuser = 0 point, 1 duration)
// write the control point and duration stores and return nothing; an
// evaluate transfer (tuser = 2) returns one result of Q15.16 positions.
// Configure curve_order, point_count and segment_count while idle; a count of
// zero in either gives valid_res = 0 and a zero position. An evaluate walks
// the segments (one duration store read and compare each), then divides the
// time by the duration unless the time reaches the segment end or the
// duration is zero (one quotient bit per cycle), gathers n = order + 1 points
// one store read each, and runs the de Casteljau interpolations, each a
// multiply step and an add step on a shared three-axis unit. s_tready is high
// only while idle; a finished result sits in the output register until the
// master side takes it, and new items are accepted meanwhile.
module piecewise_bezier_evaluator
    import pbe_pkg::*;
#(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int MAX_ORDER    = DEF_MAX_ORDER,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,   // 0 curve_order, 1 point_count, 2 segment_count
    input  logic [8:0]   cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index[7:0], point_x[39:8], point_y[71:40], point_z[103:72],
    // segment_duration[135:104], query_time[167:136]
    input  logic [167:0] s_tdata,
    input  logic [1:0]   s_tuser,     // func[1:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,     // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic [0:0]   m_tuser      // valid_res[0]
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: segment walk, divide, gather, interpolation passes
    pbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores, divider, interpolation unit and output register
    pbe_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_ORDER    (MAX_ORDER),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* design/pbe_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbe_checker
    import pbe_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    // a pending result is held until taken
    `PBE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // a load transfer never produces a result
    `PBE_ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && s_tuser != FUNC_EVALUATE && !m_tvalid, !m_tvalid)
    // an invalid result carries a zero position
    `PBE_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata == 96'd0)
    // an evaluate drops s_tready in the cycle after it is accepted
    `PBE_ASSERT_NEXT(a_eval_busy, s_tvalid && s_tready && s_tuser == FUNC_EVALUATE, !s_tready)

endmodule

bind piecewise_bezier_evaluator pbe_checker u_pbe_checker (.*);
